[hdl/fhd_pkg.sv]
package fhd_pkg;

    localparam int HDR_BYTES = 12;
    localparam logic [3:0] HDR_LAST = 4'(HDR_BYTES - 1);
    localparam logic [3:0] MAGIC_END = 4'd4;
    localparam logic [3:0] REV_END = 4'd6;
    localparam logic [3:0] TYPE_END = 4'd8;
    localparam logic [15:0] TYPE_MAX = 16'd9;
    localparam logic [15:0] LOG_REV_MAX = 16'd3;

    // result kinds carried on tuser
    localparam logic [1:0] KIND_HEADER = 2'd0;
    localparam logic [1:0] KIND_PAYLOAD = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    localparam logic [1:0] ERR_COMPAT = 2'd0;
    localparam logic [1:0] ERR_LOG_TYPE = 2'd1;
    localparam logic [1:0] ERR_BAD_HEADER = 2'd2;

    localparam int CFG_INDEX_W = 3;
    localparam logic [CFG_INDEX_W-1:0] REG_MAGIC = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_VERSION = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_PAYLOAD = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_LOG_MODE = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_BATCH_TYPE = 3'd4;

    typedef struct packed {
        logic [31:0] magic_word;
        logic [15:0] protocol_version;
        logic [31:0] max_payload_bytes;
        logic        log_mode;
        logic [3:0]  batch_type_code;
    } cfg_t;

    typedef struct packed {
        logic [1:0]  result_kind;
        logic [3:0]  frame_type;
        logic [31:0] payload_length;
        logic [7:0]  payload_byte;
        logic        frame_last;
        logic [1:0]  error_code;
    } result_t;

endpackage

[hdl/fhd_cfg_regs.sv]
module fhd_cfg_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [fhd_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [31:0]                    cfg_data,
    output fhd_pkg::cfg_t                  cfg
);
    import fhd_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.magic_word        <= 32'd0;
            cfg_reg.protocol_version  <= 16'd1;
            cfg_reg.max_payload_bytes <= 32'd65536;
            cfg_reg.log_mode          <= 1'b0;
            cfg_reg.batch_type_code   <= 4'd1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_MAGIC:       cfg_reg.magic_word <= cfg_data;
                REG_VERSION:     cfg_reg.protocol_version <= cfg_data[15:0];
                REG_MAX_PAYLOAD: cfg_reg.max_payload_bytes <= cfg_data;
                REG_LOG_MODE:    cfg_reg.log_mode <= cfg_data[0];
                REG_BATCH_TYPE:  cfg_reg.batch_type_code <= cfg_data[3:0];
                default:         ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

[hdl/fhd_parser.sv]
module fhd_parser (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_accept,
    input  logic [7:0]       in_byte,
    input  fhd_pkg::cfg_t    cfg,
    output logic             res_valid,
    output fhd_pkg::result_t res
);
    import fhd_pkg::*;

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_PAYLOAD,
        PH_ERROR
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [3:0]  count_reg, count_next;
    logic [31:0] magic_reg, magic_next;
    logic [15:0] rev_reg, rev_next;
    logic [15:0] type_reg, type_next;
    logic [31:0] length_reg, length_next;
    logic [31:0] left_reg, left_next;

    logic [31:0] length_cur;
    logic        last_byte;
    logic        rev_ok;

    assign length_cur = {length_reg[23:0], in_byte};
    assign last_byte  = (left_reg <= 32'd1);
    assign rev_ok     = (rev_reg == cfg.protocol_version) ||
                        (cfg.log_mode && (rev_reg >= 16'd1) && (rev_reg <= LOG_REV_MAX));

    always_comb
    begin
        phase_next  = phase_reg;
        count_next  = count_reg;
        magic_next  = magic_reg;
        rev_next    = rev_reg;
        type_next   = type_reg;
        length_next = length_reg;
        left_next   = left_reg;
        res_valid   = 1'b0;
        res         = '0;

        if (in_accept)
        begin
            unique case (phase_reg)
                PH_PAYLOAD:
                begin
                    res_valid          = 1'b1;
                    res.result_kind    = KIND_PAYLOAD;
                    res.frame_type     = type_reg[3:0];
                    res.payload_length = length_reg;
                    res.payload_byte   = in_byte;
                    res.frame_last     = last_byte;
                    if (last_byte)
                    begin
                        left_next  = 32'd0;
                        phase_next = PH_HEADER;
                    end
                    else
                    begin
                        left_next = left_reg - 32'd1;
                    end
                end
                PH_HEADER:
                begin
                    priority if (count_reg < MAGIC_END)
                        magic_next = {magic_reg[23:0], in_byte};
                    else if (count_reg < REV_END)
                        rev_next = {rev_reg[7:0], in_byte};
                    else if (count_reg < TYPE_END)
                        type_next = {type_reg[7:0], in_byte};
                    else
                        length_next = length_cur;

                    if (count_reg != HDR_LAST)
                    begin
                        count_next = count_reg + 4'd1;
                    end
                    else
                    begin
                        // last header byte: the length is completed by this byte
                        count_next = 4'd0;
                        res_valid  = 1'b1;
                        priority if ((magic_reg != cfg.magic_word) || !rev_ok)
                        begin
                            res.result_kind = KIND_ERROR;
                            res.error_code  = ERR_COMPAT;
                            phase_next      = PH_ERROR;
                        end
                        else if (cfg.log_mode && (type_reg != {12'd0, cfg.batch_type_code}))
                        begin
                            res.result_kind = KIND_ERROR;
                            res.error_code  = ERR_LOG_TYPE;
                            phase_next      = PH_ERROR;
                        end
                        else if ((type_reg < 16'd1) || (type_reg > TYPE_MAX) ||
                                 (length_cur > cfg.max_payload_bytes))
                        begin
                            res.result_kind = KIND_ERROR;
                            res.error_code  = ERR_BAD_HEADER;
                            phase_next      = PH_ERROR;
                        end
                        else
                        begin
                            res.result_kind    = KIND_HEADER;
                            res.frame_type     = type_reg[3:0];
                            res.payload_length = length_cur;
                            left_next          = length_cur;
                            if (length_cur == 32'd0)
                            begin
                                res.frame_last = 1'b1;
                                phase_next     = PH_HEADER;
                            end
                            else
                            begin
                                phase_next = PH_PAYLOAD;
                            end
                        end
                    end
                end
                default: ;  // error phase swallows every beat
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HEADER;
            count_reg  <= 4'd0;
            magic_reg  <= 32'd0;
            rev_reg    <= 16'd0;
            type_reg   <= 16'd0;
            length_reg <= 32'd0;
            left_reg   <= 32'd0;
        end
        else
        begin
            phase_reg  <= phase_next;
            count_reg  <= count_next;
            magic_reg  <= magic_next;
            rev_reg    <= rev_next;
            type_reg   <= type_next;
            length_reg <= length_next;
            left_reg   <= left_next;
        end
    end

`ifndef ASSERT_OFF
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= HDR_LAST)
        else $error("header byte count out of range");

    a_error_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_ERROR |=> phase_reg == PH_ERROR)
        else $error("error phase left before reset");

    a_payload_left: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_PAYLOAD |-> left_reg != 32'd0)
        else $error("payload phase with no bytes left");

    a_payload_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && phase_reg == PH_PAYLOAD |-> res_valid && res.result_kind == KIND_PAYLOAD)
        else $error("payload beat gave no payload result");
`endif

endmodule

[hdl/fhd_out_stage.sv]
module fhd_out_stage (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  fhd_pkg::result_t in_res,
    output logic             in_ready,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [47:0]      m_tdata,
    output logic [1:0]       m_tuser,
    output logic             m_tlast
);
    import fhd_pkg::*;

    logic    valid_reg;
    result_t res_reg;

    assign in_ready = !valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            res_reg <= in_res;
    end

    assign m_tvalid = valid_reg;
    assign m_tuser  = res_reg.result_kind;
    assign m_tlast  = res_reg.frame_last;
    assign m_tdata  = {2'b00, res_reg.error_code, res_reg.payload_byte,
                       res_reg.payload_length, res_reg.frame_type};

`ifndef ASSERT_OFF
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> m_tvalid)
        else $error("input stalled with empty output register");
`endif

endmodule

[hdl/frame_header_deframer_core.sv]
// channel   dir  beat fields
// s_axis    in   tdata[7:0] stream_byte
// m_axis    out  tdata: frame_type, payload_length, payload_byte, error_code;
//                tuser: result_kind; tlast: frame_last
// cfg       in   cfg_we / cfg_index / cfg_data, one register write per cycle
//
// one byte accepted per cycle unless stalled; its result is registered for output
// the header check runs in the cycle of the twelfth header byte
// rst_n clears the parser to header collection and the registers to their defaults
// s_tready drops only while a result waits in the output register and m_tready is low
// after an error every byte is taken and dropped until reset
module frame_header_deframer_core (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [7:0]                     s_tdata,   // [7:0] stream_byte
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [3:0] frame_type, [35:4] payload_length, [43:36] payload_byte,
    // [45:44] error_code, [47:46] zero
    output logic [47:0]                    m_tdata,
    output logic [1:0]                     m_tuser,   // [1:0] result_kind
    output logic                           m_tlast,
    input  logic                           cfg_we,
    input  logic [fhd_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [31:0]                    cfg_data
);
    import fhd_pkg::*;

    cfg_t    cfg;
    result_t res;
    logic    res_valid;
    logic    in_accept;

    assign in_accept = s_tvalid && s_tready;

    fhd_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    fhd_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_accept (in_accept),
        .in_byte   (s_tdata),
        .cfg       (cfg),
        .res_valid (res_valid),
        .res       (res)
    );

    fhd_out_stage u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (res_valid),
        .in_res   (res),
        .in_ready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

[tb/sv/frame_header_deframer_core_tb.sv]
module frame_header_deframer_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import fhd_pkg::*;

    localparam int RANDOM_BYTES = 1360;
    localparam int STALL_LIMIT = 1000;

    typedef enum logic [1:0] {COLLECT_HEADER, PASS_PAYLOAD, DROP_ALL} deframe_state_t;

    class deframer_scoreboard;
        cfg_t           regs;
        deframe_state_t parse_state;
        logic [3:0]     hdr_idx;
        logic [31:0]    magic_acc;
        logic [15:0]    rev_acc;
        logic [15:0]    type_acc;
        logic [31:0]    len_acc;
        logic [31:0]    bytes_left;
        result_t        expected_beats[$];
        int             failures;

        function new();
            regs.magic_word = 32'd0;
            regs.protocol_version = 16'd1;
            regs.max_payload_bytes = 32'd65536;
            regs.log_mode = 1'b0;
            regs.batch_type_code = 4'd1;
            parse_state = COLLECT_HEADER;
            hdr_idx = '0;
            magic_acc = '0;
            rev_acc = '0;
            type_acc = '0;
            len_acc = '0;
            bytes_left = '0;
            failures = 0;
        endfunction

        function void set_reg(logic [CFG_INDEX_W-1:0] idx, logic [31:0] data);
            case (idx)
                REG_MAGIC:       regs.magic_word = data;
                REG_VERSION:     regs.protocol_version = data[15:0];
                REG_MAX_PAYLOAD: regs.max_payload_bytes = data;
                REG_LOG_MODE:    regs.log_mode = data[0];
                REG_BATCH_TYPE:  regs.batch_type_code = data[3:0];
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_beats.size();
        endfunction

        // called for every accepted input beat
        function void note_byte(logic [7:0] b);
            result_t r;
            logic    rev_ok;
            logic    bad;
            r = '0;
            if (parse_state == PASS_PAYLOAD)
            begin
                r.result_kind = KIND_PAYLOAD;
                r.frame_type = type_acc[3:0];
                r.payload_length = len_acc;
                r.payload_byte = b;
                r.frame_last = (bytes_left <= 32'd1);
                bytes_left = bytes_left - 32'd1;
                if (r.frame_last)
                begin
                    bytes_left = '0;
                    parse_state = COLLECT_HEADER;
                end
                expected_beats = {expected_beats, r};
                return;
            end
            if (parse_state == DROP_ALL)
                return;

            // big-endian fields shift in from the low end
            if (hdr_idx < MAGIC_END)
                magic_acc = {magic_acc[23:0], b};
            else if (hdr_idx < REV_END)
                rev_acc = {rev_acc[7:0], b};
            else if (hdr_idx < TYPE_END)
                type_acc = {type_acc[7:0], b};
            else
                len_acc = {len_acc[23:0], b};
            if (hdr_idx != HDR_LAST)
            begin
                hdr_idx = hdr_idx + 4'd1;
                return;
            end
            hdr_idx = '0;

            rev_ok = (rev_acc == regs.protocol_version) ||
                     (regs.log_mode && rev_acc >= 16'd1 && rev_acc <= LOG_REV_MAX);
            bad = 1'b1;
            if (magic_acc != regs.magic_word || !rev_ok)
                r.error_code = ERR_COMPAT;
            else if (regs.log_mode && type_acc != {12'd0, regs.batch_type_code})
                r.error_code = ERR_LOG_TYPE;
            else if (type_acc < 16'd1 || type_acc > TYPE_MAX ||
                     len_acc > regs.max_payload_bytes)
                r.error_code = ERR_BAD_HEADER;
            else
                bad = 1'b0;

            if (bad)
            begin
                r.result_kind = KIND_ERROR;
                parse_state = DROP_ALL;
            end
            else
            begin
                r.result_kind = KIND_HEADER;
                r.frame_type = type_acc[3:0];
                r.payload_length = len_acc;
                r.frame_last = (len_acc == 32'd0);
                bytes_left = len_acc;
                if (len_acc == 32'd0)
                    parse_state = COLLECT_HEADER;
                else
                    parse_state = PASS_PAYLOAD;
            end
            expected_beats = {expected_beats, r};
        endfunction

        function void match_field(string field, logic [31:0] want, logic [31:0] got);
            if (got !== want)
            begin
                $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
                failures++;
            end
        endfunction

        function void check_beat(result_t got);
            result_t want;
            if (expected_beats.size() == 0)
            begin
                $error("result beat with nothing expected (kind %0d)", got.result_kind);
                failures++;
                return;
            end
            want = expected_beats.pop_front();
            match_field("result_kind", 32'(want.result_kind), 32'(got.result_kind));
            match_field("frame_type", 32'(want.frame_type), 32'(got.frame_type));
            match_field("payload_length", want.payload_length, got.payload_length);
            match_field("payload_byte", 32'(want.payload_byte), 32'(got.payload_byte));
            match_field("frame_last", 32'(want.frame_last), 32'(got.frame_last));
            match_field("error_code", 32'(want.error_code), 32'(got.error_code));
        endfunction
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [7:0]             s_tdata = 8'd0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [47:0]            m_tdata;
    logic [1:0]             m_tuser;
    logic                   m_tlast;
    logic                   cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [31:0]            cfg_data = 32'd0;

    deframer_scoreboard sb = new();
    cfg_t               setting;
    logic               burst = 1'b0;
    int                 bytes_sent = 0;
    int                 quiet_cycles = 0;

    frame_header_deframer_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = burst ? 0 : $urandom_range(0, 5);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        do @(posedge clk); while (s_tready !== 1'b1);
        sb.note_byte(b);
        bytes_sent++;
    endtask

    task automatic send_header(input logic [31:0] magic, input logic [15:0] rev,
                               input logic [15:0] ftype, input logic [31:0] len);
        logic [95:0] hdr;
        hdr = {magic, rev, ftype, len};
        for (int i = 11; i >= 0; i--)
            send_byte(hdr[i*8 +: 8]);
    endtask

    task automatic send_frame(input logic [31:0] magic, input logic [15:0] rev,
                              input logic [15:0] ftype, input logic [31:0] len);
        send_header(magic, rev, ftype, len);
        repeat (len) send_byte(8'($urandom));
    endtask

    // drain all results, then allow for the output register before touching registers
    task automatic settle();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [31:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        sb.set_reg(idx, data);
    endtask

    // narrow registers get junk in the unused upper bits
    task automatic apply_setting(input cfg_t c);
        write_reg(REG_MAGIC, c.magic_word);
        write_reg(REG_VERSION, {16'($urandom), c.protocol_version});
        write_reg(REG_MAX_PAYLOAD, c.max_payload_bytes);
        write_reg(REG_LOG_MODE, {31'($urandom), c.log_mode});
        write_reg(REG_BATCH_TYPE, {28'($urandom), c.batch_type_code});
        if ($urandom_range(0, 2) == 0)
            write_reg(REG_BATCH_TYPE + CFG_INDEX_W'($urandom_range(1, 3)), $urandom);
        cfg_we <= 1'b0;
    endtask

    function automatic cfg_t random_setting();
        cfg_t c;
        c.magic_word = $urandom;
        c.protocol_version = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(1, 3))
                                                         : 16'($urandom);
        case ($urandom_range(0, 3))
            0: c.max_payload_bytes = $urandom_range(0, 20);
            1: c.max_payload_bytes = 32'hFFFF_FFFF;
            2: c.max_payload_bytes = $urandom;
            default: c.max_payload_bytes = $urandom_range(0, 300);
        endcase
        c.log_mode = 1'($urandom_range(0, 1));
        c.batch_type_code = 4'($urandom_range(1, TYPE_MAX));
        return c;
    endfunction

    task automatic send_good_frame();
        logic [15:0] rev;
        logic [15:0] ftype;
        logic [31:0] hi;
        logic [31:0] len;
        rev = setting.protocol_version;
        if (setting.log_mode && $urandom_range(0, 3) != 0)
            rev = 16'($urandom_range(1, LOG_REV_MAX));
        ftype = setting.log_mode ? {12'd0, setting.batch_type_code}
                                 : 16'($urandom_range(1, TYPE_MAX));
        // mostly short payloads, now and then a long one or one at the top of the chosen range
        hi = ($urandom_range(0, 9) == 0) ? 32'd200 : 32'd12;
        if (setting.max_payload_bytes < hi)
            hi = setting.max_payload_bytes;
        len = ($urandom_range(0, 7) == 0) ? hi : $urandom_range(0, hi);
        send_frame(setting.magic_word, rev, ftype, len);
    endtask

    // one failing header; the block then drops everything until reset
    task automatic send_broken_frame();
        int          variant;
        logic [31:0] magic;
        logic [15:0] rev;
        logic [15:0] ftype;
        logic [31:0] len;
        variant = $urandom_range(0, 5);
        setting = random_setting();
        case (variant)
            1: if (setting.log_mode) setting.protocol_version = 16'd0;
            2: setting.log_mode = 1'b1;
            3: setting.log_mode = 1'b0;
            4: setting.max_payload_bytes = $urandom % 32'hFFFF_FFFF;
            5:
            begin
                setting.log_mode = 1'b1;
                setting.batch_type_code = $urandom_range(0, 1) ? 4'd0
                                                               : 4'($urandom_range(10, 15));
            end
            default: ;
        endcase
        magic = setting.magic_word;
        rev = setting.protocol_version;
        ftype = setting.log_mode ? {12'd0, setting.batch_type_code}
                                 : 16'($urandom_range(1, TYPE_MAX));
        len = 32'd0;
        case (variant)
            0: magic = magic ^ (32'd1 << $urandom_range(0, 31));
            1: rev = setting.log_mode ? 16'($urandom_range(4, 65535))
                                      : rev ^ (16'd1 << $urandom_range(0, 15));
            2:
            begin
                ftype = 16'($urandom);
                if (ftype == {12'd0, setting.batch_type_code})
                    ftype = ftype ^ 16'h0100;
            end
            3: ftype = $urandom_range(0, 1) ? 16'd0 : 16'($urandom_range(10, 65535));
            4: len = $urandom_range(32'hFFFF_FFFF, setting.max_payload_bytes + 32'd1);
            default: ;
        endcase
        apply_setting(setting);
        burst = 1'b0;
        send_header(magic, rev, ftype, len);
        repeat (16) send_byte(8'($urandom));
    endtask

    // result side: random stalls, every accepted beat goes to the scoreboard
    initial
    begin
        result_t got;
        int      stall;
        forever
        begin
            stall = burst ? 0 : $urandom_range(0, 5);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (m_tvalid !== 1'b1);
            got.result_kind = m_tuser;
            got.frame_type = m_tdata[3:0];
            got.payload_length = m_tdata[35:4];
            got.payload_byte = m_tdata[43:36];
            got.error_code = m_tdata[45:44];
            got.frame_last = m_tlast;
            sb.check_beat(got);
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready === 1'b1) || (m_tvalid === 1'b1 && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("** frame_header_deframer_core: FAILED **");
            $finish;
        end
    end

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // register defaults straight out of reset
        send_frame(32'd0, 16'd1, 16'd1, 32'd0);
        send_frame(32'd0, 16'd1, 16'd9, 32'd1);
        send_frame(32'd0, 16'd1, 16'd5, 32'd3);

        settle();
        setting = '{32'hFFFF_FFFF, 16'hFFFF, 32'd0, 1'b0, 4'd9};
        apply_setting(setting);
        send_frame(32'hFFFF_FFFF, 16'hFFFF, 16'd9, 32'd0);
        send_frame(32'hFFFF_FFFF, 16'hFFFF, 16'd1, 32'd0);

        // log mode: revisions 1..3 and the programmed one, length up to the limit
        settle();
        setting = '{32'h5A0F_C3A5, 16'd0, 32'd4, 1'b1, 4'd9};
        apply_setting(setting);
        send_frame(32'h5A0F_C3A5, 16'd1, 16'd9, 32'd4);
        send_frame(32'h5A0F_C3A5, 16'd3, 16'd9, 32'd0);
        send_frame(32'h5A0F_C3A5, 16'd2, 16'd9, 32'd1);
        send_frame(32'h5A0F_C3A5, 16'd0, 16'd9, 32'd2);

        settle();
        setting = '{32'd0, 16'd1, 32'hFFFF_FFFF, 1'b1, 4'd1};
        apply_setting(setting);
        send_frame(32'd0, 16'd3, 16'd1, 32'd5);

        while (bytes_sent < RANDOM_BYTES)
        begin
            settle();
            setting = random_setting();
            apply_setting(setting);
            burst = ($urandom_range(0, 3) == 0);
            repeat ($urandom_range(2, 6)) send_good_frame();
        end

        settle();
        send_broken_frame();

        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
        if (sb.failures == 0)
            $display("** frame_header_deframer_core: PASSED **");
        else
            $display("** frame_header_deframer_core: FAILED **");
        $finish;
    end

endmodule

[frame_header_deframer_core.f]
hdl/fhd_pkg.sv
hdl/fhd_cfg_regs.sv
hdl/fhd_parser.sv
hdl/fhd_out_stage.sv
hdl/frame_header_deframer_core.sv
tb/sv/frame_header_deframer_core_tb.sv
